// ===== rtl/core/saws_pkg.sv =====
// Shared types and constants for the stop-and-wait sender.
// No dependencies; imported by stop_and_wait_sender_top.
package saws_pkg;

  localparam int unsigned CHUNK_BYTES = 2048;
  localparam int unsigned TIMER_MAX   = 16'hFFFF;

  localparam logic [3:0] F_SYN  = 4'b0001;
  localparam logic [3:0] F_ACK  = 4'b0010;
  localparam logic [3:0] F_FIN  = 4'b0100;
  localparam logic [3:0] F_PUSH = 4'b1000;
  localparam logic [3:0] F_NONE = 4'b0000;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_SEGMENT = 3'd1,
    CMD_OPEN    = 3'd2,
    CMD_HEADER  = 3'd3,
    CMD_DATA    = 3'd4,
    CMD_CLOSE   = 3'd5
  } command_t;

  typedef enum logic [2:0] {
    REG_TIMEOUT      = 3'd0,
    REG_OPEN_RETRY   = 3'd1,
    REG_HEADER_RETRY = 3'd2,
    REG_DATA_RETRY   = 3'd3,
    REG_CLOSE_RETRY  = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_SYNW = 4'd1,
    PH_OPEN = 4'd2,
    PH_HDRW = 4'd3,
    PH_DATW = 4'd4,
    PH_FINA = 4'd5,
    PH_FINF = 4'd6,
    PH_LING = 4'd7
  } phase_t;

  typedef enum logic [3:0] {
    ST_NONE            = 4'd0,
    ST_OPEN_DONE       = 4'd1,
    ST_ERROR           = 4'd2,
    ST_RETRIES_OUT     = 4'd3,
    ST_HEADER_ACKED    = 4'd4,
    ST_HEADER_ACK_BAD  = 4'd5,
    ST_CHUNK_ACKED     = 4'd6,
    ST_CLOSED          = 4'd7,
    ST_CLOSE_TIMEOUT   = 4'd8,
    ST_CLOSE_DISTURBED = 4'd9
  } status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  rx_flags;
    logic [31:0] rx_seqnum;
    logic [31:0] rx_acknum;
    logic        rx_checksum_ok;
    logic [31:0] byte_length;
  } in_t;

  typedef struct packed {
    logic        send_valid;
    logic [3:0]  tx_flags;
    logic [31:0] tx_seqnum;
    logic [31:0] tx_acknum;
    logic [31:0] tx_length;
    logic [3:0]  status;
  } out_t;

endpackage

// ===== rtl/core/stop_and_wait_sender_top.sv =====
// Stop-and-wait sender: phase control, counters, retransmit timer and result queue.
// Depends on saws_pkg.
//
// Usage
//   in channel  (in_valid/in_ready/in_data): one command per transfer - a 1 ms
//     tick, a received segment header, or a host open/header/data/close.
//   out channel (out_valid/out_ready/out_data): at most one result per command,
//     a segment header to transmit (send_valid) and/or a status event.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): timeout and retry
//     limits; always ready, write only while the block is idle.
// Timing
//   Each command is evaluated in the cycle it is accepted; its result joins
//   the output queue and shows on out_* after earlier results. One command per
//   cycle is sustained while results drain. The two-entry output queue sets
//   in_ready: it drops only when both entries hold results not yet taken.
// Reset
//   rst (synchronous) returns to idle with all counters and the last header
//   cleared, the queue empty and the registers at their defaults
//   (timeout 500 ticks, retries 2/5/2/2).
// Receiver stall
//   Results wait in the queue; once both entries are full every command,
//   including those that give no result, waits until a result is taken.
module stop_and_wait_sender_top
  import saws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [15:0] timeout_ticks;
  logic [2:0]  open_retry_limit, header_retry_limit, data_retry_limit, close_retry_limit;

  // protocol state
  phase_t      phase, phase_next;
  logic [31:0] send_seq, send_seq_next;
  logic [31:0] recv_ack, recv_ack_next;
  logic [2:0]  retry_count, retry_count_next;
  logic [15:0] wait_timer, wait_timer_next;
  logic [3:0]  last_flags, last_flags_next;
  logic [31:0] last_seq, last_seq_next;
  logic [31:0] last_ack, last_ack_next;
  logic [31:0] last_length, last_length_next;

  // result queue
  out_t        q [2];
  logic [1:0]  count;

  logic        in_fire, push, pop;
  logic        res_emit, res_send;
  status_t     res_status;
  out_t        res;

  logic        waiting, timeout_hit, retry_ok;
  logic [15:0] timer_inc;
  logic [2:0]  limit;
  logic        syn_good, ack_good, fin_good;
  logic [31:0] clip_len;
  logic [31:0] last_seq_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count != 2'd2);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = q[0];
  assign pop       = out_valid && out_ready;
  assign push      = in_fire && res_emit;

  // decode shared by phase and datapath logic
  assign waiting     = (phase == PH_SYNW) || (phase == PH_HDRW) || (phase == PH_DATW) ||
                       (phase == PH_FINA) || (phase == PH_FINF) || (phase == PH_LING);
  assign timer_inc   = (wait_timer != 16'(TIMER_MAX)) ? wait_timer + 16'd1 : wait_timer;
  assign timeout_hit = (timer_inc >= timeout_ticks);
  assign retry_ok    = (retry_count < limit);
  assign last_seq_inc = last_seq + 32'd1;

  always_comb begin
    case (phase)
      PH_SYNW: limit = open_retry_limit;
      PH_HDRW: limit = header_retry_limit;
      PH_DATW: limit = data_retry_limit;
      default: limit = close_retry_limit;
    endcase
  end

  assign syn_good = in_data.rx_checksum_ok && (in_data.rx_acknum == last_seq_inc) &&
                    ((in_data.rx_flags & (F_SYN | F_ACK)) == (F_SYN | F_ACK));
  assign ack_good = in_data.rx_checksum_ok && ((in_data.rx_flags & F_ACK) != F_NONE) &&
                    (in_data.rx_acknum == send_seq);
  assign fin_good = ack_good && ((in_data.rx_flags & F_FIN) != F_NONE);
  assign clip_len = (in_data.byte_length > 32'(CHUNK_BYTES)) ? 32'(CHUNK_BYTES)
                                                             : in_data.byte_length;

  // next phase
  always_comb begin
    phase_next = phase;
    case (command_t'(in_data.command))
      CMD_TICK: begin
        if (waiting && timeout_hit) begin
          if (phase == PH_FINF || phase == PH_LING || !retry_ok) phase_next = PH_IDLE;
        end
      end
      CMD_SEGMENT: begin
        case (phase)
          PH_SYNW: phase_next = syn_good ? PH_OPEN : PH_IDLE;
          PH_HDRW, PH_DATW: phase_next = PH_OPEN;
          PH_FINA: phase_next = ack_good ? PH_FINF : PH_IDLE;
          PH_FINF: phase_next = fin_good ? PH_LING : PH_IDLE;
          PH_LING: phase_next = PH_IDLE;
          default: phase_next = phase;
        endcase
      end
      CMD_OPEN:   if (phase == PH_IDLE) phase_next = PH_SYNW;
      CMD_HEADER: if (phase == PH_OPEN) phase_next = PH_HDRW;
      CMD_DATA:   if (phase == PH_OPEN) phase_next = PH_DATW;
      CMD_CLOSE:  if (phase == PH_OPEN) phase_next = PH_FINA;
      default:    phase_next = phase;
    endcase
  end

  // counters, last header and result
  always_comb begin
    send_seq_next    = send_seq;
    recv_ack_next    = recv_ack;
    retry_count_next = retry_count;
    wait_timer_next  = wait_timer;
    last_flags_next  = last_flags;
    last_seq_next    = last_seq;
    last_ack_next    = last_ack;
    last_length_next = last_length;
    res_emit   = 1'b0;
    res_send   = 1'b0;
    res_status = ST_NONE;
    case (command_t'(in_data.command))
      CMD_TICK: begin
        if (waiting) begin
          wait_timer_next = timeout_hit ? 16'd0 : timer_inc;
          if (timeout_hit) begin
            res_emit = 1'b1;
            if (phase == PH_FINF) begin
              res_status = ST_CLOSE_TIMEOUT;
            end else if (phase == PH_LING) begin
              res_status = ST_CLOSED;
            end else if (retry_ok) begin
              retry_count_next = retry_count + 3'd1;
              res_send = 1'b1;
            end else begin
              res_status = ST_RETRIES_OUT;
            end
          end
        end
      end
      CMD_SEGMENT: begin
        case (phase)
          PH_SYNW: begin
            res_emit = 1'b1;
            if (syn_good) begin
              send_seq_next    = send_seq + 32'd1;
              recv_ack_next    = in_data.rx_seqnum + 32'd1;
              last_flags_next  = F_ACK;
              last_seq_next    = last_seq_inc;
              last_ack_next    = in_data.rx_seqnum + 32'd1;
              last_length_next = 32'd0;
              retry_count_next = 3'd0;
              wait_timer_next  = 16'd0;
              res_send   = 1'b1;
              res_status = ST_OPEN_DONE;
            end else begin
              res_status = ST_ERROR;
            end
          end
          PH_HDRW: begin
            res_emit   = 1'b1;
            res_status = ack_good ? ST_HEADER_ACKED : ST_HEADER_ACK_BAD;
          end
          PH_DATW: begin
            res_emit   = 1'b1;
            res_status = ack_good ? ST_CHUNK_ACKED : ST_ERROR;
          end
          PH_FINA: begin
            if (ack_good) begin
              recv_ack_next   = recv_ack + 32'd1;
              wait_timer_next = 16'd0;
            end else begin
              res_emit   = 1'b1;
              res_status = ST_ERROR;
            end
          end
          PH_FINF: begin
            res_emit = 1'b1;
            if (fin_good) begin
              recv_ack_next    = recv_ack + 32'd1;
              last_flags_next  = F_ACK;
              last_seq_next    = send_seq;
              last_ack_next    = recv_ack + 32'd1;
              last_length_next = 32'd0;
              retry_count_next = 3'd0;
              wait_timer_next  = 16'd0;
              res_send = 1'b1;
            end else begin
              res_status = ST_ERROR;
            end
          end
          PH_LING: begin
            res_emit   = 1'b1;
            res_status = ST_CLOSE_DISTURBED;
          end
          default: res_emit = 1'b0;
        endcase
      end
      CMD_OPEN: begin
        if (phase == PH_IDLE) begin
          last_flags_next  = F_SYN;
          last_seq_next    = send_seq;
          last_ack_next    = 32'd0;
          last_length_next = 32'd0;
          retry_count_next = 3'd0;
          wait_timer_next  = 16'd0;
          res_emit = 1'b1;
          res_send = 1'b1;
        end
      end
      CMD_HEADER: begin
        if (phase == PH_OPEN) begin
          last_flags_next  = F_PUSH;
          last_seq_next    = send_seq;
          last_ack_next    = recv_ack;
          last_length_next = in_data.byte_length;
          retry_count_next = 3'd0;
          wait_timer_next  = 16'd0;
          send_seq_next    = send_seq + 32'd1;
          res_emit = 1'b1;
          res_send = 1'b1;
        end
      end
      CMD_DATA: begin
        if (phase == PH_OPEN) begin
          last_flags_next  = F_NONE;
          last_seq_next    = send_seq;
          last_ack_next    = recv_ack;
          last_length_next = clip_len;
          retry_count_next = 3'd0;
          wait_timer_next  = 16'd0;
          send_seq_next    = send_seq + clip_len;
          res_emit = 1'b1;
          res_send = 1'b1;
        end
      end
      CMD_CLOSE: begin
        if (phase == PH_OPEN) begin
          last_flags_next  = F_FIN;
          last_seq_next    = send_seq;
          last_ack_next    = 32'd0;
          last_length_next = 32'd0;
          retry_count_next = 3'd0;
          wait_timer_next  = 16'd0;
          send_seq_next    = send_seq + 32'd1;
          res_emit = 1'b1;
          res_send = 1'b1;
        end
      end
      default: res_emit = 1'b0;
    endcase
  end

  // header fields read as zero when nothing is sent
  always_comb begin
    res.send_valid = res_send;
    res.tx_flags   = res_send ? last_flags_next  : 4'd0;
    res.tx_seqnum  = res_send ? last_seq_next    : 32'd0;
    res.tx_acknum  = res_send ? last_ack_next    : 32'd0;
    res.tx_length  = res_send ? last_length_next : 32'd0;
    res.status     = res_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks      <= 16'd500;
      open_retry_limit   <= 3'd2;
      header_retry_limit <= 3'd5;
      data_retry_limit   <= 3'd2;
      close_retry_limit  <= 3'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_TIMEOUT:      timeout_ticks      <= cfg_data;
        REG_OPEN_RETRY:   open_retry_limit   <= cfg_data[2:0];
        REG_HEADER_RETRY: header_retry_limit <= cfg_data[2:0];
        REG_DATA_RETRY:   data_retry_limit   <= cfg_data[2:0];
        REG_CLOSE_RETRY:  close_retry_limit  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      send_seq    <= 32'd0;
      recv_ack    <= 32'd0;
      retry_count <= 3'd0;
      wait_timer  <= 16'd0;
      last_flags  <= 4'd0;
      last_seq    <= 32'd0;
      last_ack    <= 32'd0;
      last_length <= 32'd0;
    end else if (in_fire) begin
      phase       <= phase_next;
      send_seq    <= send_seq_next;
      recv_ack    <= recv_ack_next;
      retry_count <= retry_count_next;
      wait_timer  <= wait_timer_next;
      last_flags  <= last_flags_next;
      last_seq    <= last_seq_next;
      last_ack    <= last_ack_next;
      last_length <= last_length_next;
    end
  end

  // two-entry output queue, head in q[0]
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        q[0] <= res;
      end else begin
        q[0] <= q[1];
        q[1] <= res;
      end
    end else if (pop) begin
      q[0] <= q[1];
    end else if (push) begin
      if (count == 2'd0) q[0] <= res;
      else               q[1] <= res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output queue overfilled");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
      push && (count == 2'd0) |=> out_valid)
    else $error("result transfer not presented");

  a_open_syn: assert property (@(posedge clk) disable iff (rst)
      in_fire && (in_data.command == CMD_OPEN) && (phase == PH_IDLE) |=>
      (phase == PH_SYNW) && (last_flags == F_SYN))
    else $error("open did not start handshake");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
      in_fire && (in_data.command == CMD_TICK) && (phase == PH_IDLE) |=> $stable(wait_timer))
    else $error("timer moved while idle");

endmodule

// ===== test/stop_and_wait_sender_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stop_and_wait_sender_top: directed table, then random sessions.
// Holds its own model of the sender. Depends on saws_pkg and the top-level RTL only.
module stop_and_wait_sender_top_test;
  import saws_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 310;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  stop_and_wait_sender_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // link model state
  phase_t      link_phase = PH_IDLE;
  logic [31:0] next_seq = '0;
  logic [31:0] peer_ack = '0;
  logic [2:0]  retries = '0;
  logic [15:0] tick_count = '0;
  logic [3:0]  hdr_flags = '0;
  logic [31:0] hdr_seq = '0;
  logic [31:0] hdr_ack = '0;
  logic [31:0] hdr_len = '0;
  logic [15:0] cfg_timeout = 16'd500;
  logic [2:0]  lim_open = 3'd2;
  logic [2:0]  lim_header = 3'd5;
  logic [2:0]  lim_data = 3'd2;
  logic [2:0]  lim_close = 3'd2;

  out_t awaited_results[$];

  typedef struct {
    in_t  item;
    bit   typed;
    bit   typed_made;
    out_t typed_res;
  } drill_row_t;
  drill_row_t drill[$];

  bit calm = 1'b0;
  int mismatches = 0;
  int results_checked = 0;
  int commands_sent = 0;
  int settings_used = 0;

  function automatic out_t make_result(input bit with_hdr, input status_t st);
    out_t r;
    r = '0;
    r.status = st;
    if (with_hdr) begin
      r.send_valid = 1'b1;
      r.tx_flags = hdr_flags;
      r.tx_seqnum = hdr_seq;
      r.tx_acknum = hdr_ack;
      r.tx_length = hdr_len;
    end
    return r;
  endfunction

  function automatic logic [2:0] retry_limit();
    case (link_phase)
      PH_SYNW: return lim_open;
      PH_HDRW: return lim_header;
      PH_DATW: return lim_data;
      default: return lim_close;
    endcase
  endfunction

  task automatic load_header(input logic [3:0] fl, input logic [31:0] sq, input logic [31:0] ak,
                             input logic [31:0] ln);
    hdr_flags = fl;
    hdr_seq = sq;
    hdr_ack = ak;
    hdr_len = ln;
    retries = '0;
    tick_count = '0;
  endtask

  task automatic advance_link(input in_t item, output bit made, output out_t res);
    logic [31:0] len;
    bit good;
    made = 1'b0;
    res = '0;
    case (item.command)
      CMD_TICK: begin
        if (link_phase != PH_IDLE && link_phase != PH_OPEN) begin
          if (tick_count != 16'hFFFF) tick_count++;
          if (tick_count >= cfg_timeout) begin
            tick_count = '0;
            made = 1'b1;
            if (link_phase == PH_FINF) begin
              link_phase = PH_IDLE;
              res = make_result(1'b0, ST_CLOSE_TIMEOUT);
            end else if (link_phase == PH_LING) begin
              link_phase = PH_IDLE;
              res = make_result(1'b0, ST_CLOSED);
            end else if (retries < retry_limit()) begin
              retries++;
              res = make_result(1'b1, ST_NONE);
            end else begin
              link_phase = PH_IDLE;
              res = make_result(1'b0, ST_RETRIES_OUT);
            end
          end
        end
      end
      CMD_SEGMENT: begin
        case (link_phase)
          PH_SYNW: begin
            good = item.rx_checksum_ok && item.rx_acknum == hdr_seq + 32'd1 &&
                   (item.rx_flags & (F_SYN | F_ACK)) == (F_SYN | F_ACK);
            made = 1'b1;
            if (good) begin
              next_seq++;
              peer_ack = item.rx_seqnum + 32'd1;
              load_header(F_ACK, hdr_seq + 32'd1, peer_ack, '0);
              link_phase = PH_OPEN;
              res = make_result(1'b1, ST_OPEN_DONE);
            end else begin
              link_phase = PH_IDLE;
              res = make_result(1'b0, ST_ERROR);
            end
          end
          PH_HDRW, PH_DATW: begin
            good = item.rx_checksum_ok && (item.rx_flags & F_ACK) != 0 &&
                   item.rx_acknum == next_seq;
            made = 1'b1;
            if (link_phase == PH_HDRW) begin
              res = make_result(1'b0, good ? ST_HEADER_ACKED : ST_HEADER_ACK_BAD);
            end else begin
              res = make_result(1'b0, good ? ST_CHUNK_ACKED : ST_ERROR);
            end
            link_phase = PH_OPEN;
          end
          PH_FINA: begin
            good = item.rx_checksum_ok && (item.rx_flags & F_ACK) != 0 &&
                   item.rx_acknum == next_seq;
            if (good) begin
              peer_ack++;
              tick_count = '0;
              link_phase = PH_FINF;
            end else begin
              made = 1'b1;
              link_phase = PH_IDLE;
              res = make_result(1'b0, ST_ERROR);
            end
          end
          PH_FINF: begin
            good = item.rx_checksum_ok && (item.rx_flags & (F_ACK | F_FIN)) == (F_ACK | F_FIN) &&
                   item.rx_acknum == next_seq;
            made = 1'b1;
            if (good) begin
              peer_ack++;
              load_header(F_ACK, next_seq, peer_ack, '0);
              link_phase = PH_LING;
              res = make_result(1'b1, ST_NONE);
            end else begin
              link_phase = PH_IDLE;
              res = make_result(1'b0, ST_ERROR);
            end
          end
          PH_LING: begin
            made = 1'b1;
            link_phase = PH_IDLE;
            res = make_result(1'b0, ST_CLOSE_DISTURBED);
          end
          default: ;
        endcase
      end
      CMD_OPEN: begin
        if (link_phase == PH_IDLE) begin
          load_header(F_SYN, next_seq, '0, '0);
          link_phase = PH_SYNW;
          made = 1'b1;
          res = make_result(1'b1, ST_NONE);
        end
      end
      CMD_HEADER: begin
        if (link_phase == PH_OPEN) begin
          load_header(F_PUSH, next_seq, peer_ack, item.byte_length);
          next_seq++;
          link_phase = PH_HDRW;
          made = 1'b1;
          res = make_result(1'b1, ST_NONE);
        end
      end
      CMD_DATA: begin
        if (link_phase == PH_OPEN) begin
          len = (item.byte_length > CHUNK_BYTES) ? CHUNK_BYTES : item.byte_length;
          load_header(F_NONE, next_seq, peer_ack, len);
          next_seq = next_seq + len;
          link_phase = PH_DATW;
          made = 1'b1;
          res = make_result(1'b1, ST_NONE);
        end
      end
      CMD_CLOSE: begin
        if (link_phase == PH_OPEN) begin
          load_header(F_FIN, next_seq, '0, '0);
          next_seq++;
          link_phase = PH_FINA;
          made = 1'b1;
          res = make_result(1'b1, ST_NONE);
        end
      end
      default: ;
    endcase
  endtask

  // called at a rising edge; leaves in_valid high so the next transfer can follow at once
  task automatic push_cmd(input in_t item, input bit typed, input bit typed_made,
                          input out_t typed_res);
    bit made;
    out_t res;
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_link(item, made, res);
    if (typed) begin
      made = typed_made;
      res = typed_res;
    end
    if (made) awaited_results.push_back(res);
    commands_sent++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TIMEOUT:      cfg_timeout = val;
      REG_OPEN_RETRY:   lim_open = val[2:0];
      REG_HEADER_RETRY: lim_header = val[2:0];
      REG_DATA_RETRY:   lim_data = val[2:0];
      REG_CLOSE_RETRY:  lim_close = val[2:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] tmo, input logic [2:0] lo, input logic [2:0] lh,
                                input logic [2:0] ld, input logic [2:0] lc);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_OPEN_RETRY, {13'd0, lo});
    write_reg(REG_HEADER_RETRY, {13'd0, lh});
    write_reg(REG_DATA_RETRY, {13'd0, ld});
    write_reg(REG_CLOSE_RETRY, {13'd0, lc});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // hold the sender until every awaited result is in, then let silent commands finish
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_t mk(input logic [2:0] c, input logic [3:0] f, input logic [31:0] s,
                             input logic [31:0] a, input logic ok, input logic [31:0] len);
    return in_t'{c, f, s, a, ok, len};
  endfunction

  task automatic add_row(input in_t item, input bit typed, input bit made, input out_t res);
    drill.push_back('{item, typed, made, res});
  endtask

  // mostly well-formed replies for the current phase, some broken, some noise
  function automatic in_t draw_item();
    in_t it;
    int unsigned roll;
    logic [3:0] need;
    logic [31:0] target;
    it.command = CMD_TICK;
    it.rx_flags = 4'($urandom_range(15));
    it.rx_seqnum = $urandom();
    it.rx_acknum = $urandom();
    it.rx_checksum_ok = 1'b1;
    it.byte_length = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(3000);
    roll = $urandom_range(99);
    if (roll < 8) begin
      it.command = 3'($urandom_range(7));
      it.rx_checksum_ok = 1'($urandom_range(1));
      return it;
    end
    case (link_phase)
      PH_IDLE: it.command = CMD_OPEN;
      PH_OPEN: begin
        if (roll < 50) it.command = CMD_DATA;
        else if (roll < 70) it.command = CMD_HEADER;
        else if (roll < 90) it.command = CMD_CLOSE;
        else it.command = CMD_SEGMENT;
      end
      PH_LING: it.command = (roll < 75) ? CMD_TICK : CMD_SEGMENT;
      default: begin
        need = F_ACK;
        target = next_seq;
        if (link_phase == PH_SYNW) begin
          need = F_SYN | F_ACK;
          target = hdr_seq + 32'd1;
        end else if (link_phase == PH_FINF) begin
          need = F_ACK | F_FIN;
        end
        if (roll < 30) begin
          it.command = CMD_TICK;
        end else begin
          it.command = CMD_SEGMENT;
          it.rx_flags = it.rx_flags | need;
          it.rx_acknum = target;
          if (roll >= 82) begin
            case ($urandom_range(2))
              0: it.rx_checksum_ok = 1'b0;
              1: it.rx_flags = it.rx_flags & ~need;
              default: it.rx_acknum = target ^ (32'd1 << $urandom_range(31));
            endcase
          end
        end
      end
    endcase
    return it;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= (rst || calm) ? 1'b1 : ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, got %h", $time, out_data);
      end else begin
        want = awaited_results.pop_front();
        check_field("send_valid", 32'(want.send_valid), 32'(out_data.send_valid));
        check_field("tx_flags", 32'(want.tx_flags), 32'(out_data.tx_flags));
        check_field("tx_seqnum", want.tx_seqnum, out_data.tx_seqnum);
        check_field("tx_acknum", want.tx_acknum, out_data.tx_acknum);
        check_field("tx_length", want.tx_length, out_data.tx_length);
        check_field("status", 32'(want.status), 32'(out_data.status));
        results_checked++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("stop_and_wait_sender_top_test: done, errors");
    $finish;
  end

  initial begin
    out_t syn0, gave_up, bad_reply, none_res;
    int directed_count;
    syn0 = out_t'{1'b1, F_SYN, 32'd0, 32'd0, 32'd0, ST_NONE};
    gave_up = out_t'{1'b0, F_NONE, 32'd0, 32'd0, 32'd0, ST_RETRIES_OUT};
    bad_reply = out_t'{1'b0, F_NONE, 32'd0, 32'd0, 32'd0, ST_ERROR};
    none_res = '0;

    // timeout of one tick, one SYN retry, one header retry, no data retry
    add_row(mk(CMD_SEGMENT, F_SYN | F_ACK, 0, 1, 1'b1, 0), 1'b1, 1'b0, none_res);
    add_row(mk(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF),
            1'b1, 1'b0, none_res);
    add_row(mk(CMD_TICK, 0, 0, 0, 1'b0, 0), 1'b1, 1'b0, none_res);
    add_row(mk(CMD_OPEN, 0, 0, 0, 1'b0, 0), 1'b1, 1'b1, syn0);
    add_row(mk(CMD_TICK, 0, 0, 0, 1'b0, 0), 1'b1, 1'b1, syn0);
    add_row(mk(CMD_TICK, 0, 0, 0, 1'b0, 0), 1'b1, 1'b1, gave_up);
    add_row(mk(CMD_OPEN, 0, 0, 0, 1'b0, 0), 1'b1, 1'b1, syn0);
    add_row(mk(CMD_SEGMENT, F_SYN | F_ACK, 5, 1, 1'b0, 0), 1'b1, 1'b1, bad_reply);
    add_row(mk(CMD_OPEN, 0, 0, 0, 1'b0, 0), 1'b1, 1'b1, syn0);
    add_row(mk(CMD_SEGMENT, F_SYN | F_ACK, 32'hFFFF_FFFF, 1, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_OPEN, 0, 0, 0, 1'b0, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_HEADER, 0, 0, 0, 1'b1, 32'hFFFF_FFFF), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_TICK, 0, 0, 0, 1'b0, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_SEGMENT, F_ACK, 0, 2, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_HEADER, 0, 0, 0, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_SEGMENT, F_ACK, 0, 7, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_DATA, 0, 0, 0, 1'b1, 5000), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_SEGMENT, F_ACK, 0, 2051, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_CLOSE, 0, 0, 0, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_SEGMENT, F_ACK, 0, 2052, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_SEGMENT, F_ACK | F_FIN, 0, 2052, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_TICK, 0, 0, 0, 1'b0, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_OPEN, 0, 0, 0, 1'b0, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_SEGMENT, 4'hF, 0, 2053, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_CLOSE, 0, 0, 0, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_SEGMENT, F_ACK, 0, 2054, 1'b1, 0), 1'b0, 1'b0, none_res);
    add_row(mk(CMD_TICK, 0, 0, 0, 1'b0, 0), 1'b0, 1'b0, none_res);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    apply_settings(16'd1, 3'd1, 3'd1, 3'd0, 3'd2);
    foreach (drill[i]) push_cmd(drill[i].item, drill[i].typed, drill[i].typed_made,
                                drill[i].typed_res);
    directed_count = commands_sent;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: apply_settings(16'd1, 3'd0, 3'd0, 3'd0, 3'd0);
        1: apply_settings(16'd2, 3'd7, 3'd7, 3'd7, 3'd7);
        2: apply_settings(16'hFFFF, 3'd3, 3'd3, 3'd3, 3'd3);
        3: apply_settings(16'($urandom_range(1, 6)), 3'($urandom_range(7)),
                          3'($urandom_range(7)), 3'($urandom_range(7)),
                          3'($urandom_range(7)));
        default: apply_settings(16'd3, 3'($urandom_range(7)), 3'($urandom_range(7)),
                                3'($urandom_range(7)), 3'($urandom_range(7)));
      endcase
      // one phase runs with neither side idling
      calm = (p == 1);
      repeat (PHASE_ITEMS) push_cmd(draw_item(), 1'b0, 1'b0, none_res);
    end
    calm = 1'b0;
    settle();

    if (awaited_results.size() != 0) begin
      mismatches++;
      $display("%0t ns: %0d results never arrived, expected %h, got nothing", $time,
               awaited_results.size(), awaited_results[0]);
    end
    $display("covered %0d commands (%0d from the directed table) over %0d register settings",
             commands_sent, directed_count, settings_used);
    $display("compared %0d results, %0d field mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("stop_and_wait_sender_top_test: done, clean");
    end else begin
      $display("stop_and_wait_sender_top_test: done, errors");
    end
    $finish;
  end

endmodule
